@@ rtl/igq_pkg.sv @@
// igq_pkg: shared constants, types and the divider step for the integer grid quantizer
`default_nettype none

package igq_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int STEP_WIDTH  = VALUE_WIDTH - 1;

  // quotient bits resolved per divider stage
  localparam int DIV_K      = 2;
  localparam int DIV_STAGES = (VALUE_WIDTH + DIV_K - 1) / DIV_K;
  // capture, divider stages, round/clamp, multiply, output
  localparam int NUM_STAGES = DIV_STAGES + 4;
  localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

  localparam int DATA_W     = ((2 * VALUE_WIDTH + 7) / 8) * 8;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_RANGE_MIN = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_RANGE_MAX = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_SIZE = CFG_ADDR_W'(2);

  localparam logic [VALUE_WIDTH-1:0] RANGE_MIN_RST = VALUE_WIDTH'(0);
  localparam logic [VALUE_WIDTH-1:0] RANGE_MAX_RST = VALUE_WIDTH'(255);
  localparam logic [STEP_WIDTH-1:0]  STEP_RST      = STEP_WIDTH'(1);
  localparam logic [VALUE_WIDTH-1:0] SIGN_BIT      = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef logic [VALUE_WIDTH-1:0] val_t;
  typedef logic [STEP_WIDTH-1:0]  step_t;

  typedef struct packed {
    logic  rem_hi_unused;  // keeps rem/qd aligned for narrow builds
    step_t rem;            // partial remainder, always below the step
    val_t  qd;             // dividend bits still to go on top, quotient bits below
  } div_t;

  typedef struct packed {
    logic  mode;
    logic  below;          // value under range_min
    div_t  dv;
    val_t  idx_in;
  } pipe_t;

  // one restoring division step: shift in the next dividend bit, subtract if it fits
  function automatic div_t div_step(div_t d, step_t step);
    logic [VALUE_WIDTH-1:0] t;
    div_t                   o;
    t = {d.rem, d.qd[VALUE_WIDTH-1]};
    o.rem_hi_unused = 1'b0;
    o.qd = {d.qd[VALUE_WIDTH-2:0], 1'b0};
    if (t >= {1'b0, step}) begin
      t = t - {1'b0, step};
      o.qd[0] = 1'b1;
    end
    o.rem = t[STEP_WIDTH-1:0];
    return o;
  endfunction

endpackage

`default_nettype wire

@@ rtl/integer_grid_quantizer_unit.sv @@
// integer_grid_quantizer_unit: pipelined uniform quantizer, value to grid index and back
//
// Takes one word per cycle while in_tready is high and returns one word per item, in
// order, through a capture stage, a radix-4 restoring divider of DIV_STAGES stages, a
// round/clamp stage, a multiply stage and the output register. The ready chain runs
// back through every stage within the same cycle, so a stall on the output holds only
// a full pipeline and bubbles collapse.
// The last grid index (range_max-range_min)/step_size comes from a bit-serial divider
// that runs after reset and after every configuration write; in_tready stays low while
// it works. Mode 0 rounds half up and clamps to 0..last; mode 1 clamps the given index
// to last. A step size of 0 acts as 1.
`default_nettype none

module integer_grid_quantizer_unit (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // configuration
  input  wire                                  cfg_wr_en,
  input  wire  [igq_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  wire  [igq_pkg::VALUE_WIDTH-1:0]      cfg_wr_data,
  // input words
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [igq_pkg::DATA_W-1:0]           in_tdata,   // value_in, index_in
  input  wire                                  in_tuser,   // mode
  // result words
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [igq_pkg::DATA_W-1:0]           out_tdata   // grid_index, grid_value
);

  localparam int W  = igq_pkg::VALUE_WIDTH;
  localparam int D  = igq_pkg::DIV_STAGES;
  localparam int NS = igq_pkg::NUM_STAGES;

  // configuration registers
  igq_pkg::val_t  min_r, max_r;
  igq_pkg::step_t step_r;     // effective step, never zero

  // last-index unit
  logic                    busy_r, start_r;
  logic [igq_pkg::CNT_W-1:0] cnt_r;
  igq_pkg::div_t           ldiv_r, ldiv_nxt;
  igq_pkg::val_t           last_r;
  igq_pkg::val_t           lo_b, hi_b;

  // pipeline
  logic [NS-1:0]           v_r;
  logic [NS:0]             adv;
  igq_pkg::pipe_t          pipe_r [0:D];
  igq_pkg::pipe_t          pipe_nxt [1:D];
  igq_pkg::pipe_t          cap_nxt;
  igq_pkg::val_t           ridx_r, ridx_nxt;
  igq_pkg::val_t           midx_r, prod_r;
  igq_pkg::val_t           oidx_r, oval_r;
  igq_pkg::val_t           v_in, vb_in;

  assign lo_b = min_r ^ igq_pkg::SIGN_BIT;
  assign hi_b = max_r ^ igq_pkg::SIGN_BIT;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= igq_pkg::RANGE_MIN_RST;
      max_r  <= igq_pkg::RANGE_MAX_RST;
      step_r <= igq_pkg::STEP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        igq_pkg::REG_RANGE_MIN: min_r <= cfg_wr_data;
        igq_pkg::REG_RANGE_MAX: max_r <= cfg_wr_data;
        igq_pkg::REG_STEP_SIZE: begin
          step_r <= (cfg_wr_data[W-2:0] == '0) ? igq_pkg::step_t'(1) : cfg_wr_data[W-2:0];
        end
        default: ;
      endcase
    end
  end

  // ---------------- last index, bit-serial ----------------
  assign ldiv_nxt = igq_pkg::div_step(ldiv_r, step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      start_r <= 1'b1;
      cnt_r   <= '0;
    end else if (cfg_wr_en) begin
      busy_r  <= 1'b1;
      start_r <= 1'b1;
    end else if (start_r) begin
      start_r <= 1'b0;
      cnt_r   <= igq_pkg::CNT_W'(W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - igq_pkg::CNT_W'(1);
      if (cnt_r == igq_pkg::CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_r) begin
      ldiv_r.rem_hi_unused <= 1'b0;
      ldiv_r.rem           <= '0;
      ldiv_r.qd            <= (hi_b >= lo_b) ? (hi_b - lo_b) : '0;
    end else if (busy_r) begin
      ldiv_r <= ldiv_nxt;
      if (cnt_r == igq_pkg::CNT_W'(1)) begin
        last_r <= ldiv_nxt.qd;
      end
    end
  end

  // ---------------- handshake ----------------
  always_comb begin
    adv[NS] = out_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_tready  = adv[0] && !busy_r && !cfg_wr_en;
  assign out_tvalid = v_r[NS-1];
  assign out_tdata  = igq_pkg::DATA_W'({oval_r, oidx_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_tvalid && in_tready;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // ---------------- capture: offset binary, below test, difference ----------------
  assign v_in  = in_tdata[W-1:0];
  assign vb_in = v_in ^ igq_pkg::SIGN_BIT;

  always_comb begin
    cap_nxt.mode             = in_tuser;
    cap_nxt.below            = vb_in < lo_b;
    cap_nxt.dv.rem_hi_unused = 1'b0;
    cap_nxt.dv.rem           = '0;
    cap_nxt.dv.qd            = vb_in - lo_b;
    cap_nxt.idx_in           = in_tdata[2*W-1:W];
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pipe_r[0] <= cap_nxt;
    end
  end

  // ---------------- divider stages ----------------
  for (genvar s = 1; s <= D; s++) begin : g_div
    always_comb begin
      pipe_nxt[s] = pipe_r[s-1];
      for (int j = 0; j < igq_pkg::DIV_K; j++) begin
        // last stage may have fewer bits left when the width is odd
        if ((s - 1) * igq_pkg::DIV_K + j < W) begin
          pipe_nxt[s].dv = igq_pkg::div_step(pipe_nxt[s].dv, step_r);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s]) begin
        pipe_r[s] <= pipe_nxt[s];
      end
    end
  end

  // ---------------- round half up and clamp ----------------
  always_comb begin
    logic       up;
    logic [W:0] qi;
    up = {pipe_r[D].dv.rem, 1'b0} >= {1'b0, step_r};
    qi = {1'b0, pipe_r[D].dv.qd} + {{W{1'b0}}, up};
    if (pipe_r[D].mode) begin
      ridx_nxt = (pipe_r[D].idx_in > last_r) ? last_r : pipe_r[D].idx_in;
    end else if (pipe_r[D].below) begin
      ridx_nxt = '0;
    end else begin
      ridx_nxt = (qi > {1'b0, last_r}) ? last_r : qi[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[D+1]) begin
      ridx_r <= ridx_nxt;
    end
  end

  // ---------------- multiply by the step, low word only ----------------
  always_ff @(posedge clk) begin
    if (adv[D+2]) begin
      midx_r <= ridx_r;
      prod_r <= W'(ridx_r * {1'b0, step_r});
    end
  end

  // ---------------- add the origin ----------------
  always_ff @(posedge clk) begin
    if (adv[D+3]) begin
      oidx_r <= midx_r;
      oval_r <= min_r + prod_r;
    end
  end

endmodule

`default_nettype wire

@@ rtl/igq_checker.sv @@
// igq_checker: port-level checks for the integer grid quantizer, bound to the top level
`default_nettype none

module igq_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               cfg_wr_en,
  input wire                               in_tready,
  input wire                               out_tvalid,
  input wire                               out_tready,
  input wire [igq_pkg::DATA_W-1:0]         out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed or dropped while stalled");

  // reset empties the pipeline and starts the last-index computation
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("pipeline not empty or input ready after reset");

  // a configuration write closes the input while the last index is recomputed
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> !in_tready ##1 !in_tready)
    else $error("input ready too soon after a configuration write");

endmodule

bind integer_grid_quantizer_unit igq_checker u_igq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_wr_en  (cfg_wr_en),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
